[src/three_wire_rtc_serial_master_unit_assert.svh]
// ----------------------------------------------------------------------------
// Three-wire RTC serial master assertion macros
// Shared property forms used by the unit's checks.
// ----------------------------------------------------------------------------
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_UNIT_ASSERT_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWRSM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TWRSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/twrsm_pkg.sv]
// ----------------------------------------------------------------------------
// Three-wire RTC serial master package
// Item types, kind codes and constants shared by the unit.
// ----------------------------------------------------------------------------
package twrsm_pkg;

  localparam int ByteBits  = 8;
  localparam int DelayW    = 16;
  localparam int BitIdxW   = $clog2(ByteBits);
  localparam logic [DelayW-1:0] RtcDelayTime = 16'd8;
  localparam logic [BitIdxW-1:0] LastBit = BitIdxW'(ByteBits - 1);

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [ByteBits-1:0] command;
    logic [ByteBits-1:0] write_data;
    logic                data_pin_in;
  } in_item_t;

  typedef struct packed {
    logic                serial_clock;
    logic                data_pin_out;
    logic                data_drive;
    logic                chip_enable;
    logic                busy_res;
    logic                done_res;
    logic [ByteBits-1:0] read_data;
  } out_item_t;

endpackage

[src/three_wire_rtc_serial_master_unit.sv]
// ----------------------------------------------------------------------------
// Three-wire RTC serial master
// Drives chip enable, serial clock and a bidirectional data line, advancing
// one tick per accepted item and returning one status item per input item.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  in_      | input     | in_valid / in_stall  | twrsm_pkg::in_item_t
//  out_     | output    | out_valid / out_stall | twrsm_pkg::out_item_t
//  cfg_     | input     | cfg_wr_en            | 16-bit delay in ticks
//
// Each accepted item's result is registered in the output register; one item
// can be accepted per cycle while in_stall is low.
// A full output register stalls the input only while out_stall is high.
// Synchronous active-low reset sets the delay to eight ticks and idles the bus.
// ----------------------------------------------------------------------------
`include "three_wire_rtc_serial_master_unit_assert.svh"

module three_wire_rtc_serial_master_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  twrsm_pkg::in_item_t           in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output twrsm_pkg::out_item_t          out_data,
  input  logic                          cfg_wr_en,
  input  logic [twrsm_pkg::DelayW-1:0]  cfg_wr_data
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_CMD_LOW, PH_CMD_HIGH, PH_TURN,
    PH_RD_LOW, PH_RD_HIGH, PH_WR_LOW, PH_WR_HIGH, PH_END
  } phase_t;

  phase_t                              phase_r, phase_nxt;
  logic [twrsm_pkg::BitIdxW-1:0]       bit_index_r, bit_index_nxt;
  logic [twrsm_pkg::ByteBits-1:0]      cmd_shift_r, cmd_shift_nxt;
  logic [twrsm_pkg::ByteBits-1:0]      data_shift_r, data_shift_nxt;
  logic [twrsm_pkg::ByteBits-1:0]      read_acc_r, read_acc_nxt;
  logic [twrsm_pkg::DelayW-1:0]        wait_count_r, wait_count_nxt;
  logic [twrsm_pkg::DelayW-1:0]        delay_r;
  logic [twrsm_pkg::DelayW-1:0]        reload_val;
  logic                                is_write_r, is_write_nxt;
  logic                                sclk_r, sclk_nxt;
  logic                                dout_r, dout_nxt;
  logic                                drive_r, drive_nxt;
  logic                                ce_r, ce_nxt;
  logic                                done_nxt;
  logic                                out_valid_r;
  twrsm_pkg::out_item_t                out_data_r;
  twrsm_pkg::out_item_t                result;
  logic                                in_accept;

  assign in_stall   = out_valid_r & out_stall;
  assign in_accept  = in_valid & ~in_stall;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign reload_val = (delay_r == '0) ? twrsm_pkg::DelayW'(1) : delay_r;

  always_comb begin
    phase_nxt      = phase_r;
    bit_index_nxt  = bit_index_r;
    cmd_shift_nxt  = cmd_shift_r;
    data_shift_nxt = data_shift_r;
    read_acc_nxt   = read_acc_r;
    wait_count_nxt = wait_count_r;
    is_write_nxt   = is_write_r;
    sclk_nxt       = sclk_r;
    dout_nxt       = dout_r;
    drive_nxt      = drive_r;
    ce_nxt         = ce_r;
    done_nxt       = 1'b0;
    if (in_accept) begin
      if (phase_r == PH_IDLE) begin
        if (in_data.kind == twrsm_pkg::KIND_READ || in_data.kind == twrsm_pkg::KIND_WRITE) begin
          is_write_nxt   = (in_data.kind == twrsm_pkg::KIND_WRITE);
          cmd_shift_nxt  = in_data.command;
          data_shift_nxt = is_write_nxt ? in_data.write_data : '0;
          bit_index_nxt  = '0;
          sclk_nxt       = 1'b0;
          dout_nxt       = 1'b0;
          drive_nxt      = 1'b1;
          ce_nxt         = 1'b1;
          phase_nxt      = PH_START;
          wait_count_nxt = reload_val;
        end
      end else if (wait_count_r > twrsm_pkg::DelayW'(1)) begin
        wait_count_nxt = wait_count_r - twrsm_pkg::DelayW'(1);
      end else begin
        wait_count_nxt = reload_val;
        case (phase_r)
          PH_START: begin
            sclk_nxt  = 1'b0;
            dout_nxt  = cmd_shift_r[0];
            phase_nxt = PH_CMD_LOW;
          end
          PH_CMD_LOW: begin
            sclk_nxt  = 1'b1;
            phase_nxt = PH_CMD_HIGH;
          end
          PH_CMD_HIGH: begin
            cmd_shift_nxt = cmd_shift_r >> 1;
            if (bit_index_r != twrsm_pkg::LastBit) begin
              bit_index_nxt = bit_index_r + 1'b1;
              sclk_nxt      = 1'b0;
              dout_nxt      = cmd_shift_r[1];
              phase_nxt     = PH_CMD_LOW;
            end else begin
              bit_index_nxt = '0;
              if (is_write_r) begin
                sclk_nxt  = 1'b0;
                dout_nxt  = data_shift_r[0];
                phase_nxt = PH_WR_LOW;
              end else begin
                dout_nxt  = 1'b0;
                drive_nxt = 1'b0;
                phase_nxt = PH_TURN;
              end
            end
          end
          PH_TURN: begin
            sclk_nxt  = 1'b0;
            phase_nxt = PH_RD_LOW;
          end
          PH_RD_LOW: begin
            sclk_nxt = 1'b1;
            if (in_data.data_pin_in) begin
              data_shift_nxt[bit_index_r] = 1'b1;
            end
            phase_nxt = PH_RD_HIGH;
          end
          PH_RD_HIGH: begin
            sclk_nxt = 1'b0;
            if (bit_index_r != twrsm_pkg::LastBit) begin
              bit_index_nxt = bit_index_r + 1'b1;
              phase_nxt     = PH_RD_LOW;
            end else begin
              ce_nxt    = 1'b0;
              phase_nxt = PH_END;
            end
          end
          PH_WR_LOW: begin
            sclk_nxt  = 1'b1;
            phase_nxt = PH_WR_HIGH;
          end
          PH_WR_HIGH: begin
            data_shift_nxt = data_shift_r >> 1;
            sclk_nxt       = 1'b0;
            if (bit_index_r != twrsm_pkg::LastBit) begin
              bit_index_nxt = bit_index_r + 1'b1;
              dout_nxt      = data_shift_r[1];
              phase_nxt     = PH_WR_LOW;
            end else begin
              ce_nxt    = 1'b0;
              phase_nxt = PH_END;
            end
          end
          PH_END: begin
            if (!is_write_r) begin
              read_acc_nxt = data_shift_r;
            end
            sclk_nxt       = 1'b0;
            dout_nxt       = 1'b0;
            drive_nxt      = 1'b0;
            ce_nxt         = 1'b0;
            phase_nxt      = PH_IDLE;
            bit_index_nxt  = '0;
            done_nxt       = 1'b1;
            wait_count_nxt = '0;
          end
          default: begin
            sclk_nxt       = 1'b0;
            dout_nxt       = 1'b0;
            drive_nxt      = 1'b0;
            ce_nxt         = 1'b0;
            phase_nxt      = PH_IDLE;
            wait_count_nxt = '0;
          end
        endcase
      end
    end
  end

  always_comb begin
    result.serial_clock = sclk_nxt;
    result.data_pin_out = drive_nxt & dout_nxt;
    result.data_drive   = drive_nxt;
    result.chip_enable  = ce_nxt;
    result.busy_res     = (phase_nxt != PH_IDLE);
    result.done_res     = done_nxt;
    result.read_data    = read_acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_index_r  <= '0;
      cmd_shift_r  <= '0;
      data_shift_r <= '0;
      read_acc_r   <= '0;
      wait_count_r <= '0;
      is_write_r   <= 1'b0;
      sclk_r       <= 1'b0;
      dout_r       <= 1'b0;
      drive_r      <= 1'b0;
      ce_r         <= 1'b0;
      delay_r      <= twrsm_pkg::RtcDelayTime;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      bit_index_r  <= bit_index_nxt;
      cmd_shift_r  <= cmd_shift_nxt;
      data_shift_r <= data_shift_nxt;
      read_acc_r   <= read_acc_nxt;
      wait_count_r <= wait_count_nxt;
      is_write_r   <= is_write_nxt;
      sclk_r       <= sclk_nxt;
      dout_r       <= dout_nxt;
      drive_r      <= drive_nxt;
      ce_r         <= ce_nxt;
      if (cfg_wr_en) begin
        delay_r <= cfg_wr_data;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
        out_data_r  <= result;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `TWRSM_ASSERT_SAME(a_wait_tracks_phase, 1'b1, (phase_r != PH_IDLE) == (wait_count_r != '0), "wait count out of step with phase")
  `TWRSM_ASSERT_SAME(a_ce_only_busy, out_valid_r && out_data_r.chip_enable, out_data_r.busy_res, "chip enable high while idle")
  `TWRSM_ASSERT_SAME(a_done_ends_busy, out_valid_r && out_data_r.done_res, !out_data_r.busy_res && !out_data_r.data_drive, "done reported with transfer still open")
  `TWRSM_ASSERT_NEXT(a_idle_start, in_accept && phase_r == PH_IDLE && in_data.kind == twrsm_pkg::KIND_WRITE, phase_r == PH_START && is_write_r && ce_r, "write start not taken from idle")

endmodule
